// ===== sv/alu_with_condition_codes_core_assert.svh =====
// ---------------------------------------------------------------------------
// ALU condition-code core assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ALU_WITH_CONDITION_CODES_CORE_ASSERT_SVH
`define ALU_WITH_CONDITION_CODES_CORE_ASSERT_SVH

// same-cycle implication
`define ALUCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ALUCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/alucc_pkg.sv =====
// ---------------------------------------------------------------------------
// ALU condition-code core package
// Operation codes, decode classes, back-end states and the decoded control.
// ---------------------------------------------------------------------------
`default_nettype none

package alucc_pkg;

    typedef enum logic [4:0] {
        F_MOV  = 5'd0,
        F_ADD  = 5'd1,
        F_SUB  = 5'd2,
        F_SWAP = 5'd3,
        F_MUL  = 5'd4,
        F_DIV  = 5'd5,
        F_CMP  = 5'd6,
        F_SHL  = 5'd7,
        F_SHR  = 5'd8,
        F_AND  = 5'd9,
        F_OR   = 5'd10,
        F_XOR  = 5'd11,
        F_JMP  = 5'd12,
        F_JZ   = 5'd13,
        F_JP   = 5'd14,
        F_JN   = 5'd15,
        F_JNZ  = 5'd16,
        F_JNP  = 5'd17,
        F_JNN  = 5'd18,
        F_NOT  = 5'd19,
        F_STOP = 5'd20
    } func_t;

    typedef enum logic [2:0] {
        CL_ALU      = 3'd0,
        CL_MUL      = 3'd1,
        CL_DIV      = 3'd2,
        CL_DIV_ZERO = 3'd3,
        CL_BRANCH   = 3'd4,
        CL_NONE     = 3'd5
    } op_class_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } back_state_t;

    typedef struct packed {
        func_t     func;
        op_class_t cls;
        logic      shift_sat;
    } dec_t;

    localparam int FLAG_Z_BIT = 0;
    localparam int FLAG_N_BIT = 1;

endpackage

`default_nettype wire

// ===== sv/alucc_if.sv =====
// ---------------------------------------------------------------------------
// ALU condition-code core channels
// Command, response and configuration channels with valid/ready transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface alucc_cmd_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [4:0]                   func;
    logic signed [DATA_WIDTH-1:0] first_operand;
    logic signed [DATA_WIDTH-1:0] second_operand;

    modport source (output valid, func, first_operand, second_operand, input ready);
    modport sink   (input valid, func, first_operand, second_operand, output ready);
endinterface

interface alucc_rsp_if #(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] first_value;
    logic                         write_first;
    logic signed [DATA_WIDTH-1:0] second_value;
    logic                         write_second;
    logic signed [DATA_WIDTH-1:0] remainder;
    logic                         write_remainder;
    logic [1:0]                   flags;
    logic                         branch_taken;
    logic [ADDR_WIDTH-1:0]        branch_target;
    logic                         divide_by_zero;

    modport source (output valid, first_value, write_first, second_value, write_second,
                    remainder, write_remainder, flags, branch_taken, branch_target,
                    divide_by_zero, input ready);
    modport sink   (input valid, first_value, write_first, second_value, write_second,
                    remainder, write_remainder, flags, branch_taken, branch_target,
                    divide_by_zero, output ready);
endinterface

interface alucc_cfg_if #(
    parameter int ADDR_WIDTH = 16
);
    logic                  valid;
    logic                  ready;
    logic [ADDR_WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/alucc_front.sv =====
// ---------------------------------------------------------------------------
// ALU condition-code core front end
// Accepts commands, classifies them by execution unit and pushes the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module alucc_front import alucc_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int QW         = $bits(dec_t) + 2 * DATA_WIDTH
) (
    alucc_cmd_if.sink      cmd,
    input  logic           q_full,
    output logic           q_push,
    output logic [QW-1:0]  q_data
);

    localparam logic [DATA_WIDTH-1:0] SHIFT_LIM = DATA_WIDTH'(DATA_WIDTH);

    func_t                 func_v;
    dec_t                  dec;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;

    assign a      = cmd.first_operand;
    assign b      = cmd.second_operand;
    assign func_v = func_t'(cmd.func);

    always_comb
    begin
        dec.func      = func_v;
        dec.shift_sat = (b >= SHIFT_LIM);
        case (func_v)
            F_MUL:
            begin
                dec.cls = CL_MUL;
            end
            F_DIV:
            begin
                dec.cls = (b == '0) ? CL_DIV_ZERO : CL_DIV;
            end
            F_JMP, F_JZ, F_JP, F_JN, F_JNZ, F_JNP, F_JNN, F_STOP:
            begin
                dec.cls = CL_BRANCH;
            end
            F_MOV, F_ADD, F_SUB, F_SWAP, F_CMP, F_SHL, F_SHR, F_AND, F_OR, F_XOR, F_NOT:
            begin
                dec.cls = CL_ALU;
            end
            default:
            begin
                dec.cls = CL_NONE;
            end
        endcase
    end

    assign cmd.ready = !q_full;
    assign q_push    = cmd.valid && !q_full;
    assign q_data    = {dec, a, b};

endmodule

`default_nettype wire

// ===== sv/alucc_fifo.sv =====
// ---------------------------------------------------------------------------
// ALU condition-code core queue
// Short first-in first-out queue between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module alucc_fifo #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/alucc_back.sv =====
// ---------------------------------------------------------------------------
// ALU condition-code core back end
// Executes queued operations, iterates multiply and divide, holds the flags.
// ---------------------------------------------------------------------------
`default_nettype none

`include "alu_with_condition_codes_core_assert.svh"

module alucc_back import alucc_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 16,
    parameter int QW         = $bits(dec_t) + 2 * DATA_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  logic [QW-1:0]  q_data,
    output logic           q_pop,
    alucc_cfg_if.sink      cfg,
    alucc_rsp_if.source    rsp
);

    localparam int DW   = DATA_WIDTH;
    localparam int SHW  = $clog2(DATA_WIDTH);
    localparam int CNTW = $clog2(DATA_WIDTH);
    localparam logic [CNTW-1:0] CNT_START = CNTW'(DATA_WIDTH - 1);

    function automatic logic [1:0] flags_of(input logic [DW-1:0] v);
        logic zero;
        zero = (v == '0);
        flags_of[FLAG_Z_BIT] = zero;
        flags_of[FLAG_N_BIT] = !zero && v[DW-1];
    endfunction

    dec_t                    dec;
    logic [DW-1:0]           a, b;
    logic signed [DW-1:0]    a_s;
    logic [DW-1:0]           sum, diff, shl, shr;
    logic                    jump;
    logic                    free;

    logic [DW-1:0]           sc_fv, sc_sv;
    logic                    sc_wf, sc_ws, sc_bt, sc_dz, sc_set;
    logic [ADDR_WIDTH-1:0]   sc_tgt;

    logic [DW:0]             div_sh, div_diff;
    logic [DW-1:0]           fin_fv, fin_rem;

    back_state_t             state_reg, state_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic [DW-1:0]           p_reg, p_next;
    logic [DW-1:0]           x_reg, x_next;
    logic [DW-1:0]           y_reg, y_next;
    logic                    is_div_reg, is_div_next;
    logic                    neg_q_reg, neg_q_next;
    logic                    neg_r_reg, neg_r_next;
    logic [1:0]              flags_reg, flags_next;
    logic [ADDR_WIDTH-1:0]   csize_reg, csize_next;

    logic                    ovalid_reg, ovalid_next;
    logic [DW-1:0]           fv_reg, fv_next;
    logic                    wf_reg, wf_next;
    logic [DW-1:0]           sv_reg, sv_next;
    logic                    ws_reg, ws_next;
    logic [DW-1:0]           rem_reg, rem_next;
    logic                    wr_reg, wr_next;
    logic [1:0]              fl_reg, fl_next;
    logic                    bt_reg, bt_next;
    logic [ADDR_WIDTH-1:0]   tgt_reg, tgt_next;
    logic                    dz_reg, dz_next;

    assign dec  = q_data[QW-1 -: $bits(dec_t)];
    assign a    = q_data[2*DW-1:DW];
    assign b    = q_data[DW-1:0];
    assign a_s  = a;
    assign sum  = a + b;
    assign diff = a - b;
    assign shl  = dec.shift_sat ? '0 : (a << b[SHW-1:0]);
    assign shr  = dec.shift_sat ? {DW{a[DW-1]}} : DW'(a_s >>> b[SHW-1:0]);
    assign free = !ovalid_reg || rsp.ready;

    always_comb
    begin
        case (dec.func)
            F_JMP:   jump = 1'b1;
            F_JZ:    jump = flags_reg[FLAG_Z_BIT];
            F_JP:    jump = (flags_reg == 2'b00);
            F_JN:    jump = flags_reg[FLAG_N_BIT];
            F_JNZ:   jump = !flags_reg[FLAG_Z_BIT];
            F_JNP:   jump = (flags_reg != 2'b00);
            F_JNN:   jump = !flags_reg[FLAG_N_BIT];
            default: jump = 1'b0;
        endcase
    end

    always_comb
    begin
        sc_fv  = '0;
        sc_sv  = '0;
        sc_wf  = 1'b0;
        sc_ws  = 1'b0;
        sc_bt  = 1'b0;
        sc_dz  = 1'b0;
        sc_set = 1'b0;
        sc_tgt = '0;
        case (dec.func)
            F_MOV:
            begin
                sc_fv = b;
                sc_wf = 1'b1;
            end
            F_ADD:
            begin
                sc_fv  = sum;
                sc_wf  = 1'b1;
                sc_set = 1'b1;
            end
            F_SUB:
            begin
                sc_fv  = diff;
                sc_wf  = 1'b1;
                sc_set = 1'b1;
            end
            F_SWAP:
            begin
                sc_fv = b;
                sc_wf = 1'b1;
                sc_sv = a;
                sc_ws = 1'b1;
            end
            F_DIV:
            begin
                sc_dz  = 1'b1;
                sc_bt  = 1'b1;
                sc_tgt = csize_reg;
            end
            F_CMP:
            begin
                sc_fv  = diff;
                sc_set = 1'b1;
            end
            F_SHL:
            begin
                sc_fv = shl;
                sc_wf = 1'b1;
            end
            F_SHR:
            begin
                sc_fv = shr;
                sc_wf = 1'b1;
            end
            F_AND:
            begin
                sc_fv  = a & b;
                sc_wf  = 1'b1;
                sc_set = 1'b1;
            end
            F_OR:
            begin
                sc_fv  = a | b;
                sc_wf  = 1'b1;
                sc_set = 1'b1;
            end
            F_XOR:
            begin
                sc_fv  = a ^ b;
                sc_wf  = 1'b1;
                sc_set = 1'b1;
            end
            F_NOT:
            begin
                sc_fv  = ~a;
                sc_wf  = 1'b1;
                sc_set = 1'b1;
            end
            F_STOP:
            begin
                sc_bt  = 1'b1;
                sc_tgt = csize_reg;
            end
            default:
            begin
                sc_bt  = jump;
                sc_tgt = jump ? ADDR_WIDTH'(a) : '0;
            end
        endcase
    end

    assign div_sh   = {p_reg, x_reg[DW-1]};
    assign div_diff = div_sh - {1'b0, y_reg};
    assign fin_fv   = is_div_reg ? (neg_q_reg ? '0 - x_reg : x_reg) : p_reg;
    assign fin_rem  = neg_r_reg ? '0 - p_reg : p_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        p_next      = p_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        is_div_next = is_div_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        flags_next  = flags_reg;
        csize_next  = cfg.valid ? cfg.data : csize_reg;
        q_pop       = 1'b0;

        ovalid_next = ovalid_reg && !rsp.ready;
        fv_next     = fv_reg;
        wf_next     = wf_reg;
        sv_next     = sv_reg;
        ws_next     = ws_reg;
        rem_next    = rem_reg;
        wr_next     = wr_reg;
        fl_next     = fl_reg;
        bt_next     = bt_reg;
        tgt_next    = tgt_reg;
        dz_next     = dz_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (dec.cls)
                        CL_MUL:
                        begin
                            q_pop       = 1'b1;
                            p_next      = '0;
                            x_next      = a;
                            y_next      = b;
                            cnt_next    = CNT_START;
                            is_div_next = 1'b0;
                            state_next  = ST_MUL;
                        end
                        CL_DIV:
                        begin
                            q_pop       = 1'b1;
                            p_next      = '0;
                            x_next      = a[DW-1] ? '0 - a : a;
                            y_next      = b[DW-1] ? '0 - b : b;
                            neg_q_next  = a[DW-1] ^ b[DW-1];
                            neg_r_next  = a[DW-1];
                            cnt_next    = CNT_START;
                            is_div_next = 1'b1;
                            state_next  = ST_DIV;
                        end
                        default:
                        begin
                            if (free)
                            begin
                                q_pop       = 1'b1;
                                ovalid_next = 1'b1;
                                fv_next     = (dec.func == F_CMP) ? '0 : sc_fv;
                                wf_next     = sc_wf;
                                sv_next     = sc_sv;
                                ws_next     = sc_ws;
                                rem_next    = '0;
                                wr_next     = 1'b0;
                                bt_next     = sc_bt;
                                tgt_next    = sc_tgt;
                                dz_next     = sc_dz;
                                if (sc_set)
                                begin
                                    flags_next = flags_of(sc_fv);
                                end
                                fl_next     = sc_set ? flags_of(sc_fv) : flags_reg;
                            end
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                p_next   = p_reg + (y_reg[0] ? x_reg : '0);
                x_next   = x_reg << 1;
                y_next   = y_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (!div_diff[DW])
                begin
                    p_next = div_diff[DW-1:0];
                    x_next = {x_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    p_next = div_sh[DW-1:0];
                    x_next = {x_reg[DW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (free)
                begin
                    ovalid_next = 1'b1;
                    fv_next     = fin_fv;
                    wf_next     = 1'b1;
                    sv_next     = '0;
                    ws_next     = 1'b0;
                    rem_next    = is_div_reg ? fin_rem : '0;
                    wr_next     = is_div_reg;
                    bt_next     = 1'b0;
                    tgt_next    = '0;
                    dz_next     = 1'b0;
                    flags_next  = flags_of(fin_fv);
                    fl_next     = flags_of(fin_fv);
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            flags_reg  <= '0;
            csize_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            flags_reg  <= flags_next;
            csize_reg  <= csize_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        is_div_reg <= is_div_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        fv_reg     <= fv_next;
        wf_reg     <= wf_next;
        sv_reg     <= sv_next;
        ws_reg     <= ws_next;
        rem_reg    <= rem_next;
        wr_reg     <= wr_next;
        fl_reg     <= fl_next;
        bt_reg     <= bt_next;
        tgt_reg    <= tgt_next;
        dz_reg     <= dz_next;
    end

    assign cfg.ready           = 1'b1;
    assign rsp.valid           = ovalid_reg;
    assign rsp.first_value     = fv_reg;
    assign rsp.write_first     = wf_reg;
    assign rsp.second_value    = sv_reg;
    assign rsp.write_second    = ws_reg;
    assign rsp.remainder       = rem_reg;
    assign rsp.write_remainder = wr_reg;
    assign rsp.flags           = fl_reg;
    assign rsp.branch_taken    = bt_reg;
    assign rsp.branch_target   = tgt_reg;
    assign rsp.divide_by_zero  = dz_reg;

    `ALUCC_ASSERT_IMP(a_flags_legal, 1'b1, flags_reg != 2'b11, "flags both negative and zero")
    `ALUCC_ASSERT_IMP(a_dz_no_write, ovalid_reg && dz_reg, !wf_reg && !wr_reg && bt_reg, "divide by zero writes back")
    `ALUCC_ASSERT_IMP(a_no_pop_busy, state_reg != ST_IDLE, !q_pop, "queue pops while a unit is busy")
    `ALUCC_ASSERT_NXT(a_iter_end, (state_reg == ST_MUL || state_reg == ST_DIV) && cnt_reg == '0, state_reg == ST_FIN, "iteration overruns its count")

endmodule

`default_nettype wire

// ===== sv/alu_with_condition_codes_core.sv =====
// ---------------------------------------------------------------------------
// ALU with negative/zero condition codes
// Executes one virtual-machine instruction per command on fetched operands.
// ---------------------------------------------------------------------------
// A command is decoded by the front end and queued (two entries) for the back
// end, so commands keep transferring while a result waits on rsp. Move, add,
// subtract, swap, compare, shifts, logic, not, jumps, stop and a divide by
// zero are executed from the idle state, back to back while rsp is free.
// Multiply and divide run on a shift-add / restoring-divide unit that retires
// one bit a cycle. Jumps test the flags left by the operation ahead of them.
// code_segment_size, the target of stop and divide by zero, is to be written
// on cfg while the core is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module alu_with_condition_codes_core import alucc_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    alucc_cmd_if.sink   cmd,
    alucc_rsp_if.source rsp,
    alucc_cfg_if.sink   cfg
);

    localparam int QW = $bits(dec_t) + 2 * DATA_WIDTH;

    logic          q_push;
    logic          q_full;
    logic [QW-1:0] q_wdata;
    logic          q_pop;
    logic          q_valid;
    logic [QW-1:0] q_rdata;

    alucc_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .QW         (QW)
    ) u_front (
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    alucc_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_rdata)
    );

    alucc_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_WIDTH (ADDR_WIDTH),
        .QW         (QW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/alu_with_condition_codes_core_test.sv =====
// ---------------------------------------------------------------------------
// ALU condition-code core testbench
// Sends instructions over cmd and checks each response on rsp against an
// in-order prediction of values, write enables, remainder, flags and branch.
// The run covers reset flags, edge operands, every operation, undefined
// codes and several code segment sizes. It then runs random phases in which
// cmd and rsp stall in turn, followed by a phase with no stalls.
// ---------------------------------------------------------------------------
module alu_with_condition_codes_core_test import alucc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 16;
    localparam int RANDOM_ITEMS = 570;
    localparam int SETTLE_CYCLES = 2 * DATA_WIDTH + 8;

    localparam logic [4:0] FUNC_UNDEF_FIRST = 5'(int'(F_STOP) + 1);
    localparam logic [4:0] FUNC_UNDEF_LAST = '1;
    localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] WORD_ONES = '1;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] first_value;
        logic                  write_first;
        logic [DATA_WIDTH-1:0] second_value;
        logic                  write_second;
        logic [DATA_WIDTH-1:0] remainder;
        logic                  write_remainder;
        logic [1:0]            flags;
        logic                  branch_taken;
        logic [ADDR_WIDTH-1:0] branch_target;
        logic                  divide_by_zero;
    } alu_result_t;

    logic clk = 1'b0;
    logic rst_n;

    alucc_cmd_if #(.DATA_WIDTH(DATA_WIDTH)) cmd_ch ();
    alucc_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .ADDR_WIDTH(ADDR_WIDTH)) rsp_ch ();
    alucc_cfg_if #(.ADDR_WIDTH(ADDR_WIDTH)) cfg_ch ();

    alu_with_condition_codes_core #(
        .DATA_WIDTH(DATA_WIDTH),
        .ADDR_WIDTH(ADDR_WIDTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .rsp  (rsp_ch),
        .cfg  (cfg_ch)
    );

    alu_result_t           expected_results[$];
    logic [1:0]            cond_flags;
    logic [ADDR_WIDTH-1:0] code_seg_size;
    int                    error_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [1:0] flags_for(logic [DATA_WIDTH-1:0] v);
        logic [1:0] f;
        f = '0;
        if (v == '0)
            f[FLAG_Z_BIT] = 1'b1;
        else if (v[DATA_WIDTH-1])
            f[FLAG_N_BIT] = 1'b1;
        return f;
    endfunction

    function automatic alu_result_t execute_instruction(logic [4:0] op,
                                                        logic [DATA_WIDTH-1:0] a,
                                                        logic [DATA_WIDTH-1:0] b);
        alu_result_t                  r;
        logic signed [DATA_WIDTH-1:0] sa;
        logic signed [DATA_WIDTH-1:0] sb;
        logic [DATA_WIDTH-1:0]        flag_src;
        logic                         set_flags;
        logic                         jump;
        r = '0;
        sa = a;
        sb = b;
        flag_src = '0;
        set_flags = 1'b0;
        jump = 1'b0;
        case (op)
            F_MOV:
            begin
                r.first_value = b;
                r.write_first = 1'b1;
            end
            F_ADD:
            begin
                r.first_value = a + b;
                r.write_first = 1'b1;
                set_flags = 1'b1;
            end
            F_SUB:
            begin
                r.first_value = a - b;
                r.write_first = 1'b1;
                set_flags = 1'b1;
            end
            F_SWAP:
            begin
                r.first_value = b;
                r.write_first = 1'b1;
                r.second_value = a;
                r.write_second = 1'b1;
            end
            F_MUL:
            begin
                r.first_value = a * b;
                r.write_first = 1'b1;
                set_flags = 1'b1;
            end
            F_DIV:
            begin
                if (b == '0)
                begin
                    r.divide_by_zero = 1'b1;
                    r.branch_taken = 1'b1;
                    r.branch_target = code_seg_size;
                end
                else
                begin
                    if (a == WORD_MIN && b == WORD_ONES)
                    begin
                        r.first_value = WORD_MIN;
                        r.remainder = '0;
                    end
                    else
                    begin
                        r.first_value = sa / sb;
                        r.remainder = sa % sb;
                    end
                    r.write_first = 1'b1;
                    r.write_remainder = 1'b1;
                    set_flags = 1'b1;
                end
            end
            F_CMP:
            begin
                flag_src = a - b;
                set_flags = 1'b1;
            end
            F_SHL:
            begin
                r.first_value = (b >= DATA_WIDTH) ? '0 : (a << b);
                r.write_first = 1'b1;
            end
            F_SHR:
            begin
                r.first_value = (b >= DATA_WIDTH) ? {DATA_WIDTH{a[DATA_WIDTH-1]}}
                                                  : DATA_WIDTH'(sa >>> b);
                r.write_first = 1'b1;
            end
            F_AND:
            begin
                r.first_value = a & b;
                r.write_first = 1'b1;
                set_flags = 1'b1;
            end
            F_OR:
            begin
                r.first_value = a | b;
                r.write_first = 1'b1;
                set_flags = 1'b1;
            end
            F_XOR:
            begin
                r.first_value = a ^ b;
                r.write_first = 1'b1;
                set_flags = 1'b1;
            end
            F_NOT:
            begin
                r.first_value = ~a;
                r.write_first = 1'b1;
                set_flags = 1'b1;
            end
            F_JMP: jump = 1'b1;
            F_JZ:  jump = cond_flags[FLAG_Z_BIT];
            F_JP:  jump = (cond_flags == '0);
            F_JN:  jump = cond_flags[FLAG_N_BIT];
            F_JNZ: jump = !cond_flags[FLAG_Z_BIT];
            F_JNP: jump = (cond_flags != '0);
            F_JNN: jump = !cond_flags[FLAG_N_BIT];
            F_STOP:
            begin
                r.branch_taken = 1'b1;
                r.branch_target = code_seg_size;
            end
            default: ;
        endcase
        if (set_flags)
            cond_flags = flags_for(op == F_CMP ? flag_src : r.first_value);
        if (jump)
        begin
            r.branch_taken = 1'b1;
            r.branch_target = a[ADDR_WIDTH-1:0];
        end
        r.flags = cond_flags;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_field(string name, logic [DATA_WIDTH-1:0] got,
                                 logic [DATA_WIDTH-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        alu_result_t got;
        alu_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.first_value     = rsp_ch.first_value;
            got.write_first     = rsp_ch.write_first;
            got.second_value    = rsp_ch.second_value;
            got.write_second    = rsp_ch.write_second;
            got.remainder       = rsp_ch.remainder;
            got.write_remainder = rsp_ch.write_remainder;
            got.flags           = rsp_ch.flags;
            got.branch_taken    = rsp_ch.branch_taken;
            got.branch_target   = rsp_ch.branch_target;
            got.divide_by_zero  = rsp_ch.divide_by_zero;
            if (expected_results.size() == 0)
                report_mismatch("response transfer with no instruction outstanding");
            else
            begin
                want = expected_results.pop_front();
                compare_field("first_value", got.first_value, want.first_value);
                compare_field("write_first", got.write_first, want.write_first);
                compare_field("second_value", got.second_value, want.second_value);
                compare_field("write_second", got.write_second, want.write_second);
                compare_field("remainder", got.remainder, want.remainder);
                compare_field("write_remainder", got.write_remainder, want.write_remainder);
                compare_field("flags", got.flags, want.flags);
                compare_field("branch_taken", got.branch_taken, want.branch_taken);
                compare_field("branch_target", got.branch_target, want.branch_target);
                compare_field("divide_by_zero", got.divide_by_zero, want.divide_by_zero);
            end
        end
    end

    task automatic send_instruction(logic [4:0] op, logic [DATA_WIDTH-1:0] a,
                                    logic [DATA_WIDTH-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.func           <= op;
        cmd_ch.first_operand  <= a;
        cmd_ch.second_operand <= b;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        expected_results.push_back(execute_instruction(op, a, b));
    endtask

    task automatic wait_drain();
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_code_seg_size(logic [ADDR_WIDTH-1:0] size);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= size;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        code_seg_size = size;
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        case ($urandom_range(7))
            0: return '0;
            1: return 1;
            2: return WORD_ONES;
            3: return WORD_MIN;
            4: return WORD_MAX;
            5: return DATA_WIDTH'($urandom_range(32)) - 16;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_instruction(F_JP, 32'h1234_ABCD, '0);
        send_instruction(F_JNP, 32'h0000_FFFF, '0);
        send_instruction(F_STOP, '0, '0);
        send_instruction(F_MOV, WORD_MAX, WORD_MIN);
        send_instruction(F_ADD, WORD_MAX, 1);
        send_instruction(F_JN, 32'hFFFF_0042, '0);
        send_instruction(F_SUB, 5, 5);
        send_instruction(F_JZ, 32'h0000_8001, '0);
        send_instruction(F_SWAP, WORD_MIN, WORD_ONES);
        send_instruction(F_MUL, 32'h0001_0000, 32'h0001_0000);
        send_instruction(F_DIV, -7, 2);
        send_instruction(F_DIV, 7, -2);
        send_instruction(F_DIV, WORD_MIN, WORD_ONES);
        send_instruction(F_DIV, 123, '0);
        send_instruction(F_CMP, 3, 5);
        send_instruction(F_JNN, 32'h0000_1111, '0);
        send_instruction(F_SHL, 1, DATA_WIDTH - 1);
        send_instruction(F_SHL, WORD_ONES, DATA_WIDTH);
        send_instruction(F_SHR, WORD_MIN, DATA_WIDTH + 1);
        send_instruction(F_SHR, WORD_MAX, WORD_ONES);
        send_instruction(F_SHR, WORD_MIN, 4);
        send_instruction(F_AND, 32'hF0F0_F0F0, 32'h0F0F_0F0F);
        send_instruction(F_JNZ, 32'h0000_2222, '0);
        send_instruction(F_OR, WORD_MIN, 1);
        send_instruction(F_XOR, WORD_ONES, WORD_MAX);
        send_instruction(F_NOT, WORD_ONES, '0);
        send_instruction(F_JMP, WORD_ONES, WORD_ONES);
        send_instruction(FUNC_UNDEF_FIRST, WORD_ONES, WORD_ONES);
        send_instruction(FUNC_UNDEF_LAST, WORD_MIN, WORD_ONES);
    endtask

    task automatic test_code_segment_size();
        write_code_seg_size('1);
        send_instruction(F_STOP, '0, '0);
        send_instruction(F_DIV, WORD_ONES, '0);
        write_code_seg_size('0);
        send_instruction(F_STOP, WORD_ONES, WORD_ONES);
        write_code_seg_size(ADDR_WIDTH'($urandom()));
        send_instruction(F_DIV, 1, '0);
        send_instruction(F_STOP, '0, '0);
    endtask

    task automatic test_random_phase(int send_pct, int recv_pct);
        logic [4:0]            op;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        write_code_seg_size(ADDR_WIDTH'($urandom()));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(19) == 0)
                op = 5'($urandom_range(int'(FUNC_UNDEF_LAST), int'(FUNC_UNDEF_FIRST)));
            else
                op = 5'($urandom_range(int'(F_STOP)));
            a = pick_operand();
            b = pick_operand();
            if ($urandom_range(7) == 0)
                b = a;
            if ((op == F_SHL || op == F_SHR) && $urandom_range(1) == 0)
                b = DATA_WIDTH'($urandom_range(DATA_WIDTH + 8));
            if (op == F_DIV && $urandom_range(9) == 0)
                b = '0;
            if (i != 0 && (i == RANDOM_ITEMS / 2 || $urandom_range(199) == 0))
                wait_drain();
            send_instruction(op, a, b);
        end
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.func         <= '0;
        cmd_ch.first_operand  <= '0;
        cmd_ch.second_operand <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        cond_flags    = '0;
        code_seg_size = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_code_segment_size();
        test_random_phase(7, 45);
        test_random_phase(45, 7);
        test_random_phase(0, 0);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/alucc_pkg.sv
sv/alucc_if.sv
sv/alucc_front.sv
sv/alucc_fifo.sv
sv/alucc_back.sv
sv/alu_with_condition_codes_core.sv
tb/alu_with_condition_codes_core_test.sv
